@@ hdl/bidirectional_map_table_macros.svh @@
// Assertion macros shared by the map table RTL.
`ifndef BIDIRECTIONAL_MAP_TABLE_MACROS_SVH
`define BIDIRECTIONAL_MAP_TABLE_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define BMT_ASSERT_NOW(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("map table check failed");

// Check that a condition implies a consequence in the next cycle.
`define BMT_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("map table check failed");

`endif

@@ hdl/bmt_pkg.sv @@
// Shared constants, operation codes and payload types of the map table.
package bmt_pkg;

    localparam int DefaultDepth     = 16;
    localparam int DefaultKeyBits   = 32;
    localparam int DefaultValueBits = 32;

    localparam int OpWidth    = 3;
    localparam int KeyWidth   = 32;
    localparam int ValueWidth = 32;
    localparam int CountWidth = 5;

    localparam logic [OpWidth-1:0] OP_PUT        = 3'd0;
    localparam logic [OpWidth-1:0] OP_LOOKUP_KEY = 3'd1;
    localparam logic [OpWidth-1:0] OP_LOOKUP_VAL = 3'd2;
    localparam logic [OpWidth-1:0] OP_REMOVE_KEY = 3'd3;
    localparam logic [OpWidth-1:0] OP_REMOVE_VAL = 3'd4;

    typedef struct packed {
        logic [OpWidth-1:0]    op;
        logic [KeyWidth-1:0]   key;
        logic [ValueWidth-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic                  found;
        logic [KeyWidth-1:0]   key_out;
        logic [ValueWidth-1:0] value_out;
        logic [CountWidth-1:0] pair_count;
        logic                  overflow;
    } rsp_t;

endpackage

@@ hdl/bmt_mem.sv @@
// Slot storage: one write port, one read port with registered read data.
module bmt_mem
    import bmt_pkg::*;
#(
    parameter int DEPTH = DefaultDepth,
    parameter int WIDTH = 1 + DefaultKeyBits + DefaultValueBits,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] storage_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one slot and read one slot per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            storage_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= storage_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/bidirectional_map_table.sv @@
// Top level of the bidirectional key/value map table with a scanning controller.
// Each operation reads all DEPTH slots of the slot memory, one slot per cycle.
// The done strobe is registered from the finish state, reached from the scan for lookups
// and unused codes, through a drop state for removals, and the drops and write for puts.
// start is taken again in the cycle that done is high; the receiver cannot stall.
// After reset a clearing pass holds busy high and empties every slot.
`include "bidirectional_map_table_macros.svh"

module bidirectional_map_table
    import bmt_pkg::*;
#(
    parameter int DEPTH      = DefaultDepth,
    parameter int KEY_BITS   = DefaultKeyBits,
    parameter int VALUE_BITS = DefaultValueBits
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic done,
    output rsp_t rsp
);

    localparam int AW        = $clog2(DEPTH);
    localparam int CW        = $clog2(DEPTH + 1);
    localparam int WordBits  = 1 + KEY_BITS + VALUE_BITS;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_SCAN   = 7'b0000100,
        ST_DROP_K = 7'b0001000,
        ST_DROP_V = 7'b0010000,
        ST_WRITE  = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         addr_reg;
    logic                  issued_reg;
    logic                  cmp_vld_reg, cmp_last_reg;
    logic [AW-1:0]         cmp_addr_reg;
    logic                  done_reg;
    logic [CW-1:0]         count_reg, count_next;
    rsp_t                  rsp_reg, rsp_next;

    logic [OpWidth-1:0]    op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;

    logic                  kfound_reg, vfound_reg, free_found_reg;
    logic [AW-1:0]         kidx_reg, vidx_reg, free_idx_reg;
    logic [VALUE_BITS-1:0] kpart_reg;
    logic [KEY_BITS-1:0]   vpart_reg;

    logic                  accept, addr_last, scan_rd;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [WordBits-1:0]   wr_data, rd_data;
    logic                  rd_valid;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_value;
    logic                  match_k, match_v, match_free;
    logic                  same_slot, tgt_ok;
    logic [AW-1:0]         tgt;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign addr_last = (addr_reg == AW'(DEPTH - 1));
    assign scan_rd   = (state_reg == ST_SCAN) && !issued_reg;

    // Slot memory; reads happen only in the scan and writes only in the clearing pass or
    // after the scan, so a read never meets a write to the same slot
    bmt_mem #(
        .DEPTH (DEPTH),
        .WIDTH (WordBits)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (scan_rd),
        .rd_addr (addr_reg),
        .rd_data (rd_data)
    );

    // Split the read word and compare against the operands
    assign rd_valid   = rd_data[WordBits-1];
    assign rd_key     = rd_data[KEY_BITS+VALUE_BITS-1 -: KEY_BITS];
    assign rd_value   = rd_data[VALUE_BITS-1:0];
    assign match_k    = cmp_vld_reg && rd_valid && (rd_key == key_reg) && !kfound_reg;
    assign match_v    = cmp_vld_reg && rd_valid && (rd_value == value_reg) && !vfound_reg;
    assign match_free = cmp_vld_reg && !rd_valid && !free_found_reg;

    // Pick the lowest slot that is free once the matched pairs are dropped
    always_comb
    begin
        same_slot = kfound_reg && vfound_reg && (kidx_reg == vidx_reg);
        tgt       = free_idx_reg;
        tgt_ok    = free_found_reg;
        if (kfound_reg && (!tgt_ok || (kidx_reg < tgt)))
        begin
            tgt    = kidx_reg;
            tgt_ok = 1'b1;
        end
        if (vfound_reg && (!tgt_ok || (vidx_reg < tgt)))
        begin
            tgt    = vidx_reg;
            tgt_ok = 1'b1;
        end
    end

    // Drive the memory write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
            end
            ST_DROP_K:
            begin
                wr_en   = kfound_reg;
                wr_addr = kidx_reg;
            end
            ST_DROP_V:
            begin
                wr_en   = vfound_reg;
                wr_addr = vidx_reg;
            end
            ST_WRITE:
            begin
                wr_en   = tgt_ok;
                wr_addr = tgt;
                wr_data = {1'b1, key_reg, value_reg};
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Sequence the operation
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (addr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cmp_last_reg)
                begin
                    if (op_reg == OP_PUT || op_reg == OP_REMOVE_KEY)
                    begin
                        state_next = ST_DROP_K;
                    end
                    else if (op_reg == OP_REMOVE_VAL)
                    begin
                        state_next = ST_DROP_V;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_DROP_K:
            begin
                state_next = (op_reg == OP_PUT) ? ST_DROP_V : ST_FINISH;
            end
            ST_DROP_V:
            begin
                state_next = (op_reg == OP_PUT) ? ST_WRITE : ST_FINISH;
            end
            ST_WRITE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Form the result and the new pair count
    always_comb
    begin
        count_next         = count_reg;
        rsp_next           = '0;
        unique case (op_reg)
            OP_PUT:
            begin
                if (tgt_ok)
                begin
                    count_next = count_reg - CW'(kfound_reg)
                               - CW'(vfound_reg && !same_slot) + CW'(1);
                end
                else
                begin
                    rsp_next.overflow = 1'b1;
                end
            end
            OP_LOOKUP_KEY:
            begin
                rsp_next.found = kfound_reg;
                if (kfound_reg)
                begin
                    rsp_next.value_out = ValueWidth'(kpart_reg);
                end
            end
            OP_LOOKUP_VAL:
            begin
                rsp_next.found = vfound_reg;
                if (vfound_reg)
                begin
                    rsp_next.key_out = KeyWidth'(vpart_reg);
                end
            end
            OP_REMOVE_KEY:
            begin
                rsp_next.found = kfound_reg;
                count_next     = count_reg - CW'(kfound_reg);
            end
            OP_REMOVE_VAL:
            begin
                rsp_next.found = vfound_reg;
                count_next     = count_reg - CW'(vfound_reg);
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        rsp_next.pair_count = CountWidth'(count_next);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            addr_reg       <= '0;
            issued_reg     <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            cmp_last_reg   <= 1'b0;
            done_reg       <= 1'b0;
            count_reg      <= '0;
            kfound_reg     <= 1'b0;
            vfound_reg     <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= (state_reg == ST_FINISH);
            cmp_vld_reg  <= scan_rd;
            cmp_last_reg <= scan_rd && addr_last;
            if (state_reg == ST_FINISH)
            begin
                count_reg <= count_next;
            end
            // Restart the sweep on a transfer, advance it while clearing or scanning
            if (accept)
            begin
                addr_reg       <= '0;
                issued_reg     <= 1'b0;
                kfound_reg     <= 1'b0;
                vfound_reg     <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if (state_reg == ST_CLEAR || scan_rd)
                begin
                    addr_reg <= addr_reg + AW'(1);
                    if (addr_last)
                    begin
                        issued_reg <= 1'b1;
                    end
                end
                if (match_k)
                begin
                    kfound_reg <= 1'b1;
                end
                if (match_v)
                begin
                    vfound_reg <= 1'b1;
                end
                if (match_free)
                begin
                    free_found_reg <= 1'b1;
                end
            end
        end
    end

    // Payload registers: operands, first matches and the result
    always_ff @(posedge clk)
    begin
        cmp_addr_reg <= addr_reg;
        if (accept)
        begin
            op_reg    <= cmd.op;
            key_reg   <= KEY_BITS'(cmd.key);
            value_reg <= VALUE_BITS'(cmd.value);
        end
        if (match_k)
        begin
            kidx_reg  <= cmp_addr_reg;
            kpart_reg <= rd_value;
        end
        if (match_v)
        begin
            vidx_reg  <= cmp_addr_reg;
            vpart_reg <= rd_key;
        end
        if (match_free)
        begin
            free_idx_reg <= cmp_addr_reg;
        end
        if (state_reg == ST_FINISH)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    `BMT_ASSERT_NEXT(a_done_single, done_reg, !done_reg)
    `BMT_ASSERT_NEXT(a_accept_scans, accept, state_reg == ST_SCAN)
    `BMT_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CW'(DEPTH))
    `BMT_ASSERT_NOW(a_overflow_full, done_reg && rsp_reg.overflow,
                    !rsp_reg.found && count_reg == CW'(DEPTH))
    `BMT_ASSERT_NOW(a_clear_quiet, state_reg == ST_CLEAR, !done_reg && !cmp_vld_reg)

endmodule
